>>> src/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg: shared types and constants for the instruction scoreboard
// Request and result codes, instruction kinds, register classes, the
// controller state type and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isb_pkg;

  localparam int MAX_PER_KIND_DEF = 4;
  localparam int INT_REGS_DEF     = 32;
  localparam int FP_REGS_DEF      = 32;

  localparam int OPC_W      = 2;
  localparam int KIND_W     = 4;
  localparam int REG_W      = 5;
  localparam int UNIT_W     = 4;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_ISSUE = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_BAD   = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANT     = 3'd0,
    ST_STRUCT    = 3'd1,
    ST_WAW       = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_WAR       = 3'd4,
    ST_BYPASS    = 3'd5
  } status_t;

  localparam logic [KIND_W-1:0] K_CONTROL  = 4'd0;
  localparam logic [KIND_W-1:0] K_INT_MEM  = 4'd1;
  localparam logic [KIND_W-1:0] K_FP_MEM   = 4'd2;
  localparam logic [KIND_W-1:0] K_LOAD_IMM = 4'd3;
  localparam logic [KIND_W-1:0] K_INT_IMM  = 4'd4;
  localparam logic [KIND_W-1:0] K_INT_RR   = 4'd5;
  localparam logic [KIND_W-1:0] K_FP_ADD   = 4'd6;
  localparam logic [KIND_W-1:0] K_FP_MUL   = 4'd7;
  localparam logic [KIND_W-1:0] K_FP_DIV   = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ADD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV = 2'd2;

  typedef enum logic [1:0] {
    RT_NONE = 2'd0,
    RT_INT  = 2'd1,
    RT_FP   = 2'd2
  } rtype_t;

  typedef struct packed {
    rtype_t d;
    rtype_t s1;
    rtype_t s2;
  } kind_types_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_DEST,
    S_RD_S1,
    S_RD_S2,
    S_EXEC
  } state_t;

  typedef enum logic [1:0] {
    RS_DEST,
    RS_S1,
    RS_S2
  } rsel_t;

  typedef struct packed {
    logic  take_req;
    logic  rd_en;
    rsel_t rd_sel;
    logic  cap_dest;
    logic  cap_s1;
    logic  exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic kind_types_t kind_types(input logic [KIND_W-1:0] k);
    kind_types_t t;
    t = '{d: RT_NONE, s1: RT_NONE, s2: RT_NONE};
    unique case (k)
      K_INT_MEM:  t = '{d: RT_INT, s1: RT_INT, s2: RT_NONE};
      K_FP_MEM:   t = '{d: RT_FP, s1: RT_INT, s2: RT_NONE};
      K_LOAD_IMM: t = '{d: RT_INT, s1: RT_NONE, s2: RT_NONE};
      K_INT_IMM:  t = '{d: RT_INT, s1: RT_INT, s2: RT_NONE};
      K_INT_RR:   t = '{d: RT_INT, s1: RT_INT, s2: RT_INT};
      K_FP_ADD, K_FP_MUL, K_FP_DIV: t = '{d: RT_FP, s1: RT_FP, s2: RT_FP};
      default:    t = '{d: RT_NONE, s1: RT_NONE, s2: RT_NONE};
    endcase
    return t;
  endfunction

  // Register number modulo a file size of at least eight; a few
  // conditional subtracts cover every 5-bit number.
  function automatic logic [5:0] wrap_reg(input logic [REG_W-1:0] r, input int n);
    logic [5:0] v;
    logic [5:0] m;
    v = {1'b0, r};
    m = 6'(n);
    for (int i = 0; i < 4; i++) begin
      if (n < 64 && v >= m) v = v - m;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/isb_if.sv
// ----------------------------------------------------------------------------
// isb_if: channel interfaces of the instruction scoreboard
// Request, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface isb_in_if;
  logic                          valid;
  logic                          ready;
  logic [isb_pkg::OPC_W-1:0]     opcode;
  logic [isb_pkg::KIND_W-1:0]    instr_kind;
  logic [isb_pkg::REG_W-1:0]     dest_reg;
  logic [isb_pkg::REG_W-1:0]     src_one_reg;
  logic [isb_pkg::REG_W-1:0]     src_two_reg;
  logic [isb_pkg::UNIT_W-1:0]    unit_sel;

  modport source (output valid, opcode, instr_kind, dest_reg, src_one_reg, src_two_reg,
                  unit_sel, input ready);
  modport sink (input valid, opcode, instr_kind, dest_reg, src_one_reg, src_two_reg,
                unit_sel, output ready);
endinterface

interface isb_out_if;
  logic                       valid;
  logic                       ready;
  logic [isb_pkg::STAT_W-1:0] status;
  logic [isb_pkg::UNIT_W-1:0] unit_index;

  modport source (output valid, status, unit_index, input ready);
  modport sink (input valid, status, unit_index, output ready);
endinterface

interface isb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [isb_pkg::CFG_IDX_W-1:0]  index;
  logic [isb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/instruction_scoreboard.sv
// ----------------------------------------------------------------------------
// instruction_scoreboard: scoreboard for dynamic instruction scheduling
// Issue, read-operands and write-result requests against one data unit, one
// integer unit and configurable groups of FP adders, multipliers, dividers.
//
//   channel  role  beat payload
//   in_ch    sink  opcode, instr_kind, dest_reg, src_one_reg, src_two_reg, unit_sel
//   out_ch   src   status, unit_index
//   cfg_ch   sink  index, data (always ready)
//
// Each request is accepted, then the single-port register status memory is read
// three times (destination, first and second source), then a final step updates
// the unit entries and loads the result register.
// A new request is accepted while the previous result still waits on out_ch.
// The last step holds while the result register is full and out_ch stalls.
// rst_n is synchronous; all status entries read as empty right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module instruction_scoreboard #(
  parameter int MAX_PER_KIND = isb_pkg::MAX_PER_KIND_DEF,
  parameter int INT_REGS     = isb_pkg::INT_REGS_DEF,
  parameter int FP_REGS      = isb_pkg::FP_REGS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  isb_in_if.sink   in_ch,
  isb_out_if.source out_ch,
  isb_cfg_if.sink  cfg_ch
);

  isb_pkg::ctl_cmd_t cmd;
  isb_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  isb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  isb_dp #(
    .MAX_PER_KIND (MAX_PER_KIND),
    .INT_REGS     (INT_REGS),
    .FP_REGS      (FP_REGS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_ch.opcode),
    .in_instr_kind  (in_ch.instr_kind),
    .in_dest_reg    (in_ch.dest_reg),
    .in_src_one_reg (in_ch.src_one_reg),
    .in_src_two_reg (in_ch.src_two_reg),
    .in_unit_sel    (in_ch.unit_sel),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_unit_index (out_ch.unit_index)
  );

endmodule

`default_nettype wire

>>> src/isb_ctrl.sv
// ----------------------------------------------------------------------------
// isb_ctrl: request sequencer of the instruction scoreboard
// Takes one request, walks the three register status lookups, then fires the
// update once the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output isb_pkg::ctl_cmd_t      cmd,
  input  wire isb_pkg::dp_stat_t stat
);

  isb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = isb_pkg::RS_DEST;
    unique case (state_r)
      isb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_req = 1'b1;
          state_nxt    = isb_pkg::S_RD_DEST;
        end
      end
      isb_pkg::S_RD_DEST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = isb_pkg::RS_DEST;
        state_nxt  = isb_pkg::S_RD_S1;
      end
      isb_pkg::S_RD_S1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = isb_pkg::RS_S1;
        cmd.cap_dest = 1'b1;
        state_nxt    = isb_pkg::S_RD_S2;
      end
      isb_pkg::S_RD_S2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = isb_pkg::RS_S2;
        cmd.cap_s1 = 1'b1;
        state_nxt  = isb_pkg::S_EXEC;
      end
      isb_pkg::S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = isb_pkg::S_IDLE;
        end
      end
      default: state_nxt = isb_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/isb_dp.sv
// ----------------------------------------------------------------------------
// isb_dp: datapath of the instruction scoreboard
// Unit entries, the register result status memory, unit count registers,
// hazard checks and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isb_dp #(
  parameter int MAX_PER_KIND = isb_pkg::MAX_PER_KIND_DEF,
  parameter int INT_REGS     = isb_pkg::INT_REGS_DEF,
  parameter int FP_REGS      = isb_pkg::FP_REGS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire isb_pkg::ctl_cmd_t                 cmd,
  output isb_pkg::dp_stat_t                      stat,
  input  wire logic [isb_pkg::OPC_W-1:0]         in_opcode,
  input  wire logic [isb_pkg::KIND_W-1:0]        in_instr_kind,
  input  wire logic [isb_pkg::REG_W-1:0]         in_dest_reg,
  input  wire logic [isb_pkg::REG_W-1:0]         in_src_one_reg,
  input  wire logic [isb_pkg::REG_W-1:0]         in_src_two_reg,
  input  wire logic [isb_pkg::UNIT_W-1:0]        in_unit_sel,
  input  wire logic                              cfg_we,
  input  wire logic [isb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [isb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [isb_pkg::STAT_W-1:0]             out_status,
  output logic [isb_pkg::UNIT_W-1:0]             out_unit_index
);

  localparam int NUM_UNITS = 2 + 3 * MAX_PER_KIND;
  localparam int UIW       = $clog2(NUM_UNITS);
  localparam int WW        = $clog2(NUM_UNITS + 1);
  localparam int MAXR      = (INT_REGS > FP_REGS) ? INT_REGS : FP_REGS;
  localparam int RW        = $clog2(MAXR);
  localparam int TDEPTH    = INT_REGS + FP_REGS;
  localparam int AW        = $clog2(TDEPTH);
  localparam int CW        = $clog2(MAX_PER_KIND + 1);

  // Request register.
  logic [isb_pkg::OPC_W-1:0]  req_op_r;
  logic [isb_pkg::KIND_W-1:0] req_kind_r;
  logic [isb_pkg::REG_W-1:0]  req_dest_r, req_s1_r, req_s2_r;
  logic [isb_pkg::UNIT_W-1:0] req_sel_r;

  // Unit entries.
  logic [NUM_UNITS-1:0]      busy_r;
  logic [isb_pkg::KIND_W-1:0] class_r [NUM_UNITS];
  logic [RW-1:0]             dest_r  [NUM_UNITS];
  logic [RW-1:0]             src1_r  [NUM_UNITS];
  logic [RW-1:0]             src2_r  [NUM_UNITS];
  logic [WW-1:0]             prod1_r [NUM_UNITS];
  logic [WW-1:0]             prod2_r [NUM_UNITS];
  logic [NUM_UNITS-1:0]      rdy1_r, rdy2_r;

  // Register result status: integer file first, FP file above it.
  logic [WW-1:0]     wr_mem [TDEPTH];
  logic [TDEPTH-1:0] wr_vld_r;
  logic [WW-1:0]     rdata_r;
  logic              rvld_r;
  logic [WW-1:0]     rd_val;
  logic [WW-1:0]     w_dest_r, w_s1_r;

  logic [CW-1:0] add_cnt_r, mul_cnt_r, div_cnt_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [isb_pkg::STAT_W-1:0] out_status_r;
  logic [isb_pkg::UNIT_W-1:0] out_unit_r;

  isb_pkg::kind_types_t kt, ukt;
  logic [RW-1:0]        dest_w, s1_w, s2_w;
  logic [31:0]          sel_ext;
  logic                 sel_ok;
  logic [UIW-1:0]       sel_idx;
  logic [WW-1:0]        sel_tag;
  logic [AW-1:0]        rd_addr;
  logic [UIW:0]         base_u, lim_u;
  logic [NUM_UNITS-1:0] cand;
  logic                 found;
  logic [UIW-1:0]       fu;
  logic [31:0]          fu_ext;
  logic                 war;

  isb_pkg::status_t           res_st;
  logic [isb_pkg::UNIT_W-1:0] res_unit;
  logic                       do_fill, do_rd_clr, do_wr_done, mem_we;
  logic [AW-1:0]              wr_addr;
  logic [WW-1:0]              wr_data;
  logic [WW-1:0]              fill_p1, fill_p2;

  function automatic logic [AW-1:0] tab_addr(input isb_pkg::rtype_t t,
                                              input logic [RW-1:0] r);
    logic [AW-1:0] a;
    a = AW'(r);
    if (t == isb_pkg::RT_FP) a = AW'(INT_REGS) + AW'(r);
    return a;
  endfunction

  function automatic logic [CW-1:0] clamp_cnt(input logic [isb_pkg::CFG_DATA_W-1:0] v);
    logic [3:0] x;
    x = {1'b0, v};
    if (x == 4'd0) x = 4'd1;
    if (x > 4'(MAX_PER_KIND)) x = 4'(MAX_PER_KIND);
    return CW'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_op_r   <= in_opcode;
      req_kind_r <= in_instr_kind;
      req_dest_r <= in_dest_reg;
      req_s1_r   <= in_src_one_reg;
      req_s2_r   <= in_src_two_reg;
      req_sel_r  <= in_unit_sel;
    end
  end

  always_comb begin
    kt      = isb_pkg::kind_types(req_kind_r);
    dest_w  = RW'(isb_pkg::wrap_reg(req_dest_r, (kt.d == isb_pkg::RT_FP) ? FP_REGS : INT_REGS));
    s1_w    = RW'(isb_pkg::wrap_reg(req_s1_r, (kt.s1 == isb_pkg::RT_FP) ? FP_REGS : INT_REGS));
    s2_w    = RW'(isb_pkg::wrap_reg(req_s2_r, (kt.s2 == isb_pkg::RT_FP) ? FP_REGS : INT_REGS));
    sel_ext = 32'(req_sel_r);
    sel_ok  = sel_ext < 32'(NUM_UNITS);
    sel_idx = sel_ok ? sel_ext[UIW-1:0] : '0;
    sel_tag = WW'(sel_idx) + WW'(1);
    ukt     = isb_pkg::kind_types(class_r[sel_idx]);
  end

  always_comb begin
    unique case (cmd.rd_sel)
      isb_pkg::RS_S1: rd_addr = tab_addr(kt.s1, s1_w);
      isb_pkg::RS_S2: rd_addr = tab_addr(kt.s2, s2_w);
      default: begin
        if (req_op_r == isb_pkg::OP_WRITE) rd_addr = tab_addr(ukt.d, dest_r[sel_idx]);
        else rd_addr = tab_addr(kt.d, dest_w);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= wr_mem[rd_addr];
      rvld_r  <= wr_vld_r[rd_addr];
    end
    if (mem_we) begin
      wr_mem[wr_addr] <= wr_data;
    end
  end

  assign rd_val = rvld_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.cap_dest) w_dest_r <= rd_val;
    if (cmd.cap_s1)   w_s1_r   <= rd_val;
  end

  // Lowest free unit of the requested kind in the packed layout.
  always_comb begin
    if (req_kind_r <= isb_pkg::K_FP_MEM) begin
      base_u = '0;
      lim_u  = (UIW+1)'(1);
    end else if (req_kind_r <= isb_pkg::K_INT_RR) begin
      base_u = (UIW+1)'(1);
      lim_u  = (UIW+1)'(2);
    end else if (req_kind_r == isb_pkg::K_FP_ADD) begin
      base_u = (UIW+1)'(2);
      lim_u  = (UIW+1)'(2) + (UIW+1)'(add_cnt_r);
    end else if (req_kind_r == isb_pkg::K_FP_MUL) begin
      base_u = (UIW+1)'(2) + (UIW+1)'(add_cnt_r);
      lim_u  = base_u + (UIW+1)'(mul_cnt_r);
    end else begin
      base_u = (UIW+1)'(2) + (UIW+1)'(add_cnt_r) + (UIW+1)'(mul_cnt_r);
      lim_u  = base_u + (UIW+1)'(div_cnt_r);
    end
    for (int c = 0; c < NUM_UNITS; c++) begin
      cand[c] = !busy_r[c] && ((UIW+1)'(c) >= base_u) && ((UIW+1)'(c) < lim_u);
    end
    found = 1'b0;
    fu    = '0;
    for (int c = NUM_UNITS - 1; c >= 0; c--) begin
      if (cand[c]) begin
        found = 1'b1;
        fu    = UIW'(c);
      end
    end
    fu_ext = 32'(fu);
  end

  // A busy unit that still has to read the old value of our destination.
  always_comb begin
    isb_pkg::kind_types_t fkt;
    war = 1'b0;
    for (int f = 0; f < NUM_UNITS; f++) begin
      fkt = isb_pkg::kind_types(class_r[f]);
      if (UIW'(f) != sel_idx && busy_r[f] && ukt.d != isb_pkg::RT_NONE) begin
        if ((fkt.s1 == ukt.d && src1_r[f] == dest_r[sel_idx] && rdy1_r[f]) ||
            (fkt.s2 == ukt.d && src2_r[f] == dest_r[sel_idx] && rdy2_r[f])) begin
          war = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_st     = isb_pkg::ST_NOT_READY;
    res_unit   = '0;
    do_fill    = 1'b0;
    do_rd_clr  = 1'b0;
    do_wr_done = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = tab_addr(kt.d, dest_w);
    wr_data    = WW'(fu) + WW'(1);
    fill_p1    = (kt.s1 != isb_pkg::RT_NONE) ? w_s1_r : '0;
    fill_p2    = (kt.s2 != isb_pkg::RT_NONE) ? rd_val : '0;
    unique case (req_op_r)
      isb_pkg::OP_ISSUE: begin
        if (req_kind_r == isb_pkg::K_CONTROL) begin
          res_st = isb_pkg::ST_BYPASS;
        end else if (kt.d == isb_pkg::RT_NONE) begin
          res_st = isb_pkg::ST_STRUCT;
        end else if (w_dest_r != '0) begin
          res_st = isb_pkg::ST_WAW;
        end else if (!found) begin
          res_st = isb_pkg::ST_STRUCT;
        end else begin
          res_st   = isb_pkg::ST_GRANT;
          res_unit = fu_ext[isb_pkg::UNIT_W-1:0];
          do_fill  = cmd.exec;
          mem_we   = cmd.exec;
        end
      end
      isb_pkg::OP_READ: begin
        res_unit = req_sel_r;
        if (req_kind_r == isb_pkg::K_CONTROL) begin
          res_st = isb_pkg::ST_BYPASS;
        end else if (sel_ok && busy_r[sel_idx] && rdy1_r[sel_idx] && rdy2_r[sel_idx]) begin
          res_st    = isb_pkg::ST_GRANT;
          do_rd_clr = cmd.exec;
        end
      end
      isb_pkg::OP_WRITE: begin
        res_unit = req_sel_r;
        if (req_kind_r == isb_pkg::K_CONTROL) begin
          res_st = isb_pkg::ST_BYPASS;
        end else if (!sel_ok || !busy_r[sel_idx]) begin
          res_st = isb_pkg::ST_NOT_READY;
        end else if (war) begin
          res_st = isb_pkg::ST_WAR;
        end else begin
          res_st     = isb_pkg::ST_GRANT;
          do_wr_done = cmd.exec;
          wr_addr    = tab_addr(ukt.d, dest_r[sel_idx]);
          wr_data    = '0;
          mem_we     = cmd.exec && ukt.d != isb_pkg::RT_NONE && w_dest_r == sel_tag;
        end
      end
      default: begin
        res_st = isb_pkg::ST_NOT_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      wr_vld_r    <= '0;
      add_cnt_r   <= CW'(1);
      mul_cnt_r   <= CW'(1);
      div_cnt_r   <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (mem_we) wr_vld_r[wr_addr] <= 1'b1;
      if (do_fill) busy_r[fu] <= 1'b1;
      if (do_wr_done) busy_r[sel_idx] <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == isb_pkg::CFG_ADD) add_cnt_r <= clamp_cnt(cfg_data);
        if (cfg_index == isb_pkg::CFG_MUL) mul_cnt_r <= clamp_cnt(cfg_data);
        if (cfg_index == isb_pkg::CFG_DIV) div_cnt_r <= clamp_cnt(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_fill) begin
      class_r[fu] <= req_kind_r;
      dest_r[fu]  <= dest_w;
      src1_r[fu]  <= (kt.s1 != isb_pkg::RT_NONE) ? s1_w : '0;
      src2_r[fu]  <= (kt.s2 != isb_pkg::RT_NONE) ? s2_w : '0;
      prod1_r[fu] <= fill_p1;
      prod2_r[fu] <= fill_p2;
      rdy1_r[fu]  <= (fill_p1 == '0);
      rdy2_r[fu]  <= (fill_p2 == '0);
    end
    if (do_rd_clr) begin
      rdy1_r[sel_idx]  <= 1'b0;
      rdy2_r[sel_idx]  <= 1'b0;
      prod1_r[sel_idx] <= '0;
      prod2_r[sel_idx] <= '0;
    end
    if (do_wr_done) begin
      for (int f = 0; f < NUM_UNITS; f++) begin
        if (UIW'(f) != sel_idx && busy_r[f]) begin
          if (prod1_r[f] == sel_tag) rdy1_r[f] <= 1'b1;
          if (prod2_r[f] == sel_tag) rdy2_r[f] <= 1'b1;
        end
      end
    end
    if (cmd.exec) begin
      out_status_r <= res_st;
      out_unit_r   <= res_unit;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.exec) out_valid_nxt = 1'b1;
  end

  assign stat.out_busy  = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_unit_index = out_unit_r;

`ifndef SYNTHESIS
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.exec))
    else $error("result beat appeared without an update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && !out_ready))
    else $error("update fired while a result beat was still held");

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (add_cnt_r != '0) && (mul_cnt_r != '0) && (div_cnt_r != '0) &&
    (add_cnt_r <= CW'(MAX_PER_KIND)) && (mul_cnt_r <= CW'(MAX_PER_KIND)) &&
    (div_cnt_r <= CW'(MAX_PER_KIND)))
    else $error("unit count register out of range");

  a_fill_free_unit: assert property (@(posedge clk) disable iff (!rst_n)
    do_fill |-> !busy_r[fu] ##1 busy_r[$past(fu)])
    else $error("issue picked a busy unit or failed to mark it busy");
`endif

endmodule

`default_nettype wire

>>> tb/tb_isb_checker.sv
// ----------------------------------------------------------------------------
// Instruction scoreboard checker
// Watches the request, result and configuration channels, keeps its own copy
// of the unit and register-status tables, predicts each result and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_isb_checker
  import isb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  isb_in_if          in_ch,
  isb_out_if         out_ch,
  isb_cfg_if         cfg_ch,
  output int         fail_count,
  output int         pending_count,
  output int         result_count,
  output int         grant_count
);

  localparam int NUNITS = 2 + 3 * MAX_PER_KIND_DEF;

  typedef struct packed {
    status_t          st;
    logic [UNIT_W-1:0] unit;
  } sb_result_t;

  sb_result_t        expected_q[$];
  logic [2:0]        n_add, n_mul, n_div;
  logic              busy[NUNITS];
  logic [KIND_W-1:0] cls[NUNITS];
  logic [5:0]        dst[NUNITS], sr1[NUNITS], sr2[NUNITS];
  logic [4:0]        prod1[NUNITS], prod2[NUNITS];
  logic              rdy1[NUNITS], rdy2[NUNITS];
  logic [4:0]        int_writer[32], fp_writer[32];

  function automatic void types_of(input logic [KIND_W-1:0] k,
                                   output rtype_t d, output rtype_t a, output rtype_t b);
    d = RT_NONE; a = RT_NONE; b = RT_NONE;
    case (k)
      K_INT_MEM, K_INT_IMM: begin d = RT_INT; a = RT_INT; end
      K_FP_MEM: begin d = RT_FP; a = RT_INT; end
      K_LOAD_IMM: d = RT_INT;
      K_INT_RR: begin d = RT_INT; a = RT_INT; b = RT_INT; end
      K_FP_ADD, K_FP_MUL, K_FP_DIV: begin d = RT_FP; a = RT_FP; b = RT_FP; end
      default: ;
    endcase
  endfunction

  function automatic logic [4:0] writer_of(input rtype_t t, input logic [5:0] r);
    if (t == RT_INT) return int_writer[r[4:0]];
    if (t == RT_FP) return fp_writer[r[4:0]];
    return 5'd0;
  endfunction

  function automatic void set_writer(input rtype_t t, input logic [5:0] r,
                                     input logic [4:0] v);
    if (t == RT_INT) int_writer[r[4:0]] = v;
    else if (t == RT_FP) fp_writer[r[4:0]] = v;
  endfunction

  function automatic logic [2:0] clamp_units(input logic [2:0] v);
    if (v == 0) return 3'd1;
    if (v > MAX_PER_KIND_DEF) return 3'(MAX_PER_KIND_DEF);
    return v;
  endfunction

  function automatic status_t schedule_issue(input logic [KIND_W-1:0] k,
      input logic [4:0] dr, input logic [4:0] r1, input logic [4:0] r2,
      output logic [UNIT_W-1:0] unit);
    rtype_t d, a, b;
    int base, cnt, u;
    unit = '0;
    if (k == K_CONTROL) return ST_BYPASS;
    types_of(k, d, a, b);
    if (d == RT_NONE) return ST_STRUCT;
    if (writer_of(d, {1'b0, dr}) != 0) return ST_WAW;
    if (k <= K_FP_MEM) begin base = 0; cnt = 1; end
    else if (k <= K_INT_RR) begin base = 1; cnt = 1; end
    else if (k == K_FP_ADD) begin base = 2; cnt = n_add; end
    else if (k == K_FP_MUL) begin base = 2 + n_add; cnt = n_mul; end
    else begin base = 2 + n_add + n_mul; cnt = n_div; end
    u = NUNITS;
    for (int i = 0; i < cnt; i++)
      if (u == NUNITS && base + i < NUNITS && !busy[base + i]) u = base + i;
    if (u >= NUNITS) return ST_STRUCT;
    busy[u] = 1'b1;
    cls[u] = k;
    dst[u] = {1'b0, dr};
    sr1[u] = (a != RT_NONE) ? {1'b0, r1} : 6'd0;
    sr2[u] = (b != RT_NONE) ? {1'b0, r2} : 6'd0;
    prod1[u] = (a != RT_NONE) ? writer_of(a, {1'b0, r1}) : 5'd0;
    prod2[u] = (b != RT_NONE) ? writer_of(b, {1'b0, r2}) : 5'd0;
    rdy1[u] = (prod1[u] == 0);
    rdy2[u] = (prod2[u] == 0);
    set_writer(d, {1'b0, dr}, 5'(u + 1));
    unit = UNIT_W'(u);
    return ST_GRANT;
  endfunction

  function automatic status_t grant_read(input int u);
    if (u >= NUNITS || !busy[u]) return ST_NOT_READY;
    if (!(rdy1[u] && rdy2[u])) return ST_NOT_READY;
    rdy1[u] = 0; rdy2[u] = 0; prod1[u] = 0; prod2[u] = 0;
    return ST_GRANT;
  endfunction

  function automatic status_t retire_write(input int u);
    rtype_t d, a, b, fd, fa, fb;
    if (u >= NUNITS || !busy[u]) return ST_NOT_READY;
    types_of(cls[u], d, a, b);
    if (d != RT_NONE)
      for (int f = 0; f < NUNITS; f++) begin
        if (f == u || !busy[f]) continue;
        types_of(cls[f], fd, fa, fb);
        if (fa == d && sr1[f] == dst[u] && rdy1[f]) return ST_WAR;
        if (fb == d && sr2[f] == dst[u] && rdy2[f]) return ST_WAR;
      end
    for (int f = 0; f < NUNITS; f++) begin
      if (f == u || !busy[f]) continue;
      if (prod1[f] == u + 1) rdy1[f] = 1;
      if (prod2[f] == u + 1) rdy2[f] = 1;
    end
    if (d != RT_NONE && writer_of(d, dst[u]) == u + 1) set_writer(d, dst[u], 5'd0);
    busy[u] = 0;
    return ST_GRANT;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    sb_result_t e, got;
    logic [UNIT_W-1:0] un;
    status_t st;
    if (!rst_n) begin
      expected_q.delete();
      n_add <= 3'd1; n_mul <= 3'd1; n_div <= 3'd1;
      for (int i = 0; i < NUNITS; i++) begin
        busy[i] = 0; cls[i] = 0; dst[i] = 0; sr1[i] = 0; sr2[i] = 0;
        prod1[i] = 0; prod2[i] = 0; rdy1[i] = 0; rdy2[i] = 0;
      end
      for (int i = 0; i < 32; i++) begin int_writer[i] = 0; fp_writer[i] = 0; end
      fail_count <= 0;
      result_count <= 0;
      grant_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_ADD: n_add <= clamp_units(cfg_ch.data);
          CFG_MUL: n_mul <= clamp_units(cfg_ch.data);
          CFG_DIV: n_div <= clamp_units(cfg_ch.data);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        un = in_ch.unit_sel;
        case (opcode_t'(in_ch.opcode))
          OP_ISSUE: st = schedule_issue(in_ch.instr_kind, in_ch.dest_reg,
                                        in_ch.src_one_reg, in_ch.src_two_reg, un);
          OP_READ:  st = (in_ch.instr_kind == K_CONTROL) ? ST_BYPASS
                         : grant_read(in_ch.unit_sel);
          OP_WRITE: st = (in_ch.instr_kind == K_CONTROL) ? ST_BYPASS
                         : retire_write(in_ch.unit_sel);
          default: begin st = ST_NOT_READY; un = '0; end
        endcase
        expected_q.push_back('{st: st, unit: un});
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{st: status_t'(out_ch.status), unit: out_ch.unit_index};
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d unit=%0d", $time,
                   got.st, got.unit);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.st == ST_GRANT) grant_count <= grant_count + 1;
          if (got.st != e.st || got.unit != e.unit) begin
            $display("%0t: mismatch expected status=%0d unit=%0d, got status=%0d unit=%0d",
                     $time, e.st, e.unit, got.st, got.unit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Instruction scoreboard testbench
// Drives directed and random issue/read/write request streams through the
// scoreboard under several unit-count settings, with random idling on both
// channels; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import isb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, result_count, grant_count;
  int   cycle_count = 0;
  bit   quiet_phase = 1'b0;

  isb_in_if  in_ch();
  isb_out_if out_ch();
  isb_cfg_if cfg_ch();

  instruction_scoreboard DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                              .cfg_ch(cfg_ch));

  tb_isb_checker checker_i (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                            .cfg_ch(cfg_ch), .fail_count(fail_count),
                            .pending_count(pending_count), .result_count(result_count),
                            .grant_count(grant_count));

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("instruction_scoreboard test failed");
      $finish;
    end
  end

  // Result-side back-pressure: out_ch.ready drops in random stall bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet_phase) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    in_ch.valid = 0; in_ch.opcode = 0; in_ch.instr_kind = 0; in_ch.dest_reg = 0;
    in_ch.src_one_reg = 0; in_ch.src_two_reg = 0; in_ch.unit_sel = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
  end

  task automatic send_request(input opcode_t op, input logic [KIND_W-1:0] k,
                              input logic [4:0] d, input logic [4:0] a,
                              input logic [4:0] b, input logic [UNIT_W-1:0] u);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op; in_ch.instr_kind <= k; in_ch.dest_reg <= d;
    in_ch.src_one_reg <= a; in_ch.src_two_reg <= b; in_ch.unit_sel <= u;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Leaves valid high so that back-to-back writes form a continuous burst;
  // the caller drops it after the last one.
  task automatic write_unit_count(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Mostly well-formed traffic: issues, plus reads and writes of existing units.
  task automatic random_traffic(input int n);
    int r;
    logic [KIND_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = 4'($urandom_range(1, 8));
      if (r < 40)
        send_request(OP_ISSUE, k, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
                     5'($urandom_range(0, 7)), 4'($urandom));
      else if (r < 65)
        send_request(OP_READ, k, 5'($urandom), 5'($urandom), 5'($urandom),
                     4'($urandom_range(0, 13)));
      else if (r < 92)
        send_request(OP_WRITE, k, 5'($urandom), 5'($urandom), 5'($urandom),
                     4'($urandom_range(0, 13)));
      else
        send_request(opcode_t'($urandom_range(0, 3)), 4'($urandom), 5'($urandom),
                     5'($urandom), 5'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every kind, control bypass, undefined kinds, bad opcode,
    // idle and nonexistent units, extreme register numbers and WAW.
    send_request(OP_ISSUE, K_CONTROL, 5'd31, 5'd31, 5'd31, 4'd15);
    send_request(OP_ISSUE, 4'd9, 5'd0, 5'd0, 5'd0, 4'd0);
    send_request(OP_ISSUE, 4'd15, 5'd31, 5'd31, 5'd31, 4'd15);
    send_request(OP_BAD, K_FP_ADD, 5'd1, 5'd2, 5'd3, 4'd7);
    send_request(OP_READ, K_FP_ADD, 5'd0, 5'd0, 5'd0, 4'd15);
    send_request(OP_WRITE, 4'd12, 5'd0, 5'd0, 5'd0, 4'd3);
    send_request(OP_ISSUE, K_FP_DIV, 5'd31, 5'd0, 5'd31, 4'd0);
    send_request(OP_ISSUE, K_FP_ADD, 5'd2, 5'd31, 5'd0, 4'd0);
    send_request(OP_ISSUE, K_FP_MUL, 5'd31, 5'd1, 5'd1, 4'd0);
    send_request(OP_ISSUE, K_FP_ADD, 5'd3, 5'd1, 5'd1, 4'd0);
    send_request(OP_ISSUE, K_LOAD_IMM, 5'd0, 5'd0, 5'd0, 4'd0);
    send_request(OP_ISSUE, K_INT_MEM, 5'd5, 5'd0, 5'd0, 4'd0);
    send_request(OP_WRITE, K_LOAD_IMM, 5'd0, 5'd0, 5'd0, 4'd1);
    send_request(OP_READ, K_INT_MEM, 5'd0, 5'd0, 5'd0, 4'd0);
    send_request(OP_WRITE, K_FP_DIV, 5'd0, 5'd0, 5'd0, 4'd4);
    send_request(OP_READ, K_CONTROL, 5'd0, 5'd0, 5'd0, 4'd2);
    send_request(OP_READ, K_FP_ADD, 5'd0, 5'd0, 5'd0, 4'd2);
    send_request(OP_WRITE, K_FP_ADD, 5'd0, 5'd0, 5'd0, 4'd2);
    send_request(OP_ISSUE, K_INT_IMM, 5'd7, 5'd5, 5'd0, 4'd0);
    send_request(OP_ISSUE, K_INT_RR, 5'd6, 5'd5, 5'd6, 4'd0);
    send_request(OP_ISSUE, K_FP_MEM, 5'd9, 5'd5, 5'd0, 4'd0);
    send_request(OP_WRITE, K_INT_MEM, 5'd0, 5'd0, 5'd0, 4'd0);
    drain_results();

    // Unit-count settings, extremes first; busy entries may outlive a change.
    for (int phase = 0; phase < 6; phase++) begin
      logic [2:0] va, vm, vd;
      case (phase)
        0: begin va = 3'd4; vm = 3'd4; vd = 3'd4; end
        1: begin va = 3'd0; vm = 3'd7; vd = 3'd1; end
        2: begin va = 3'd1; vm = 3'd1; vd = 3'd1; end
        default: begin va = 3'($urandom); vm = 3'($urandom); vd = 3'($urandom); end
      endcase
      write_unit_count(CFG_ADD, va);
      write_unit_count(CFG_MUL, vm);
      write_unit_count(CFG_DIV, vd);
      cfg_ch.valid <= 1'b0;
      if (phase == 5) quiet_phase = 1'b1;
      random_traffic(290);
      drain_results();
    end

    $display("covered %0d results (%0d granted) over six unit-count settings",
             result_count, grant_count);
    if (fail_count == 0)
      $display("instruction_scoreboard test passed");
    else
      $display("instruction_scoreboard test failed");
    $finish;
  end

endmodule
